>>> src/lpc_pkg.sv
// ----------------------------------------------------------------------------
// lpc_pkg: shared types and constants for the lever position conditioner
// Sizes of the sample ring, the window sum and the serial divider, plus the
// handshake structs between the sequencer and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

package lpc_pkg;

  localparam int WINDOW     = 8;
  localparam int SAMPLE_W   = 12;
  localparam int VALUE_W    = 15;
  localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
  localparam int FULL_SCALE = (1 << VALUE_W) - 1;

  localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W  = $clog2(WINDOW * SAMPLE_MAX + 1);
  // Scaled numerator (avg - min) * FULL_SCALE.
  localparam int NUM_W  = (SAMPLE_W + VALUE_W > SUM_W) ? SAMPLE_W + VALUE_W : SUM_W;
  localparam int DIV_W  = ($clog2(WINDOW + 1) > SAMPLE_W) ? $clog2(WINDOW + 1) : SAMPLE_W;
  localparam int Q_W    = VALUE_W;
  localparam int CNT_W  = $clog2(Q_W + 1);
  localparam int SH_W   = $clog2(NUM_W + 1);

  localparam logic [CNT_W-1:0] SCL_ITERS = CNT_W'(VALUE_W);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANGE_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SNAP_LEVEL  = 2'd2;

  localparam logic [VALUE_W-1:0] DEAD_ZONE_RST   = VALUE_W'(1000);
  localparam logic [VALUE_W-1:0] CHANGE_STEP_RST = VALUE_W'(1000);
  localparam logic [VALUE_W-1:0] SNAP_LEVEL_RST  = VALUE_W'(30000);

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] iters;
  } lpc_div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lpc_div_rsp_t;

endpackage

`default_nettype wire

>>> src/lpc_div.sv
// ----------------------------------------------------------------------------
// lpc_div: restoring serial divider
// One quotient bit per cycle. The caller gives the quotient length and
// guarantees dividend < divisor * 2**iters, so only that many steps run.
// ----------------------------------------------------------------------------
`default_nettype none

module lpc_div
  import lpc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lpc_div_req_t       req,
  input  wire logic [NUM_W-1:0]   dividend,
  input  wire logic [DIV_W-1:0]   divisor,
  output lpc_div_rsp_t            rsp,
  output logic [Q_W-1:0]          quotient
);

  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] lo_r, lo_nxt;
  logic [Q_W-1:0]   quo_r, quo_nxt;
  logic [DIV_W-1:0] div_r, div_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DIV_W:0]   trial;
  logic             ge;
  logic [SH_W-1:0]  lo_sh;

  always_comb begin
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, lo_r[NUM_W-1]};
    ge       = trial >= {1'b0, div_r};
    lo_sh    = SH_W'(NUM_W) - SH_W'(req.iters);
    if (req.start) begin
      // The bits above the quotient length already form a partial remainder.
      rem_nxt  = DIV_W'(dividend >> req.iters);
      lo_nxt   = dividend << lo_sh;
      quo_nxt  = '0;
      div_nxt  = divisor;
      cnt_nxt  = req.iters;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? DIV_W'(trial - {1'b0, div_r}) : DIV_W'(trial);
      lo_nxt  = {lo_r[NUM_W-2:0], 1'b0};
      quo_nxt = {quo_r[Q_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

>>> src/lever_position_conditioner.sv
// ----------------------------------------------------------------------------
// lever_position_conditioner: lever sample to slider value
// Boxcar average over a sample ring, scaled from the seen [min,max] range to
// full scale, with dead zone, change threshold and snap to full scale.
//
//   channel  dir  ports                               beat
//   in       in   in_valid, in_ready, in_sample       one sample
//   out      out  out_valid, out_ready, out_slider_value  one reported value
//   cfg      in   cfg_valid, cfg_ready, cfg_index, cfg_data  one register write
//
// An item is sequenced from acceptance to the reporting step. When its scaled
// value is forced to zero the divider is skipped; when it is scaled, the window
// average is a shift and the serial divider runs 15 steps for the range scaling.
// in_ready is high only while the sequencer is idle. A result waits in the
// output register; the next item is accepted meanwhile, and stalls at the
// reporting step only if the previous result has not been taken yet.
// Reset (synchronous) clears the ring through per-entry valid bits; cfg_ready
// is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module lever_position_conditioner
  import lpc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [SAMPLE_W-1:0]  in_sample,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [VALUE_W-1:0]        out_slider_value,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [VALUE_W-1:0]   cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_READ = 8'b00000010,
    S_AVG  = 8'b00000100,
    S_PREP = 8'b00001000,
    S_SCL  = 8'b00010000,
    S_SCLW = 8'b00100000,
    S_DZ   = 8'b01000000,
    S_DEC  = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;

  logic [VALUE_W-1:0]  dz_r, step_r, snap_r;
  logic [SAMPLE_W-1:0] ring_mem [WINDOW];
  logic [SAMPLE_W-1:0] rd_q;
  logic [WINDOW-1:0]   vld_r;
  logic [PTR_W-1:0]    pos_r;
  logic [SUM_W-1:0]    sum_r;
  logic [SAMPLE_W-1:0] min_r, max_r;
  logic [VALUE_W-1:0]  last_r;
  logic                first_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [SAMPLE_W-1:0] avg_r;
  logic [SAMPLE_W-1:0] d_r;
  logic [VALUE_W-1:0]  q_r;
  logic [VALUE_W-1:0]  val_r;
  logic                out_valid_r;
  logic [VALUE_W-1:0]  out_value_r;

  logic [SAMPLE_W-1:0] old_sample;
  logic [VALUE_W-1:0]  diff;
  logic [VALUE_W-1:0]  report;
  logic                out_free;
  logic                ring_wr;

  lpc_div_req_t        div_req;
  lpc_div_rsp_t        div_rsp;
  logic [NUM_W-1:0]    div_num;
  logic [DIV_W-1:0]    div_den;
  logic [Q_W-1:0]      div_quo;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_slider_value = out_value_r;
  assign out_free  = !out_valid_r || out_ready;
  assign ring_wr   = (state_r == S_READ);

  // Entries not yet written since reset read as zero.
  assign old_sample = vld_r[pos_r] ? rd_q : '0;
  assign diff   = (val_r > last_r) ? val_r - last_r : last_r - val_r;
  assign report = (val_r > snap_r) ? VALUE_W'(FULL_SCALE) : val_r;

  // Divider operands for the range scaling.
  always_comb begin
    div_req.start = (state_r == S_SCL);
    div_req.iters = SCL_ITERS;
    div_num       = (NUM_W'(d_r) << VALUE_W) - NUM_W'(d_r);
    div_den       = DIV_W'(max_r - min_r);
  end

  lpc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_num),
    .divisor  (div_den),
    .rsp      (div_rsp),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_READ;
      S_READ: state_nxt = S_AVG;
      S_AVG:  state_nxt = S_PREP;
      S_PREP: begin
        if (first_r || (max_r <= min_r) || (avg_r <= min_r)) begin
          state_nxt = S_DZ;
        end else begin
          state_nxt = S_SCL;
        end
      end
      S_SCL:  state_nxt = S_SCLW;
      S_SCLW: if (div_rsp.done) state_nxt = S_DZ;
      S_DZ:   state_nxt = S_DEC;
      S_DEC:  if (diff <= step_r || out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dz_r        <= DEAD_ZONE_RST;
      step_r      <= CHANGE_STEP_RST;
      snap_r      <= SNAP_LEVEL_RST;
      vld_r       <= '0;
      pos_r       <= '0;
      sum_r       <= '0;
      min_r       <= SAMPLE_W'(SAMPLE_MAX);
      max_r       <= '0;
      last_r      <= '0;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        priority case (cfg_index)
          REG_DEAD_ZONE:   dz_r   <= cfg_data;
          REG_CHANGE_STEP: step_r <= cfg_data;
          REG_SNAP_LEVEL:  snap_r <= cfg_data;
          default: ;
        endcase
      end
      if (ring_wr) begin
        vld_r[pos_r] <= 1'b1;
        sum_r <= sum_r - SUM_W'(old_sample) + SUM_W'(sample_r);
        if (sample_r > max_r) max_r <= sample_r;
        if (sample_r < min_r) min_r <= sample_r;
        pos_r <= (pos_r == PTR_W'(WINDOW - 1)) ? '0 : pos_r + PTR_W'(1);
      end
      if (state_r == S_PREP) first_r <= 1'b0;
      if (state_r == S_DEC && diff > step_r && out_free) begin
        out_valid_r <= 1'b1;
        last_r      <= report;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_q <= ring_mem[pos_r];
    if (ring_wr) ring_mem[pos_r] <= sample_r;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) sample_r <= in_sample;
    if (state_r == S_AVG) avg_r <= SAMPLE_W'(sum_r / SUM_W'(WINDOW));
    if (state_r == S_PREP) begin
      d_r <= avg_r - min_r;
      q_r <= '0;
    end
    if (state_r == S_SCLW && div_rsp.done) q_r <= div_quo;
    if (state_r == S_DZ) val_r <= (q_r <= dz_r) ? '0 : q_r;
    if (state_r == S_DEC && diff > step_r && out_free) out_value_r <= report;
  end

  // Assertions
  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_READ))
    else $error("accepted beat did not start the ring update");

  a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCL) |=> div_rsp.busy)
    else $error("divider did not start");

  a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
    (!first_r) |-> (min_r <= max_r))
    else $error("seen minimum above seen maximum after first sample");

  a_report_stored: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (last_r == out_value_r))
    else $error("reported value not recorded as last report");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r && $stable(out_value_r) && $stable(last_r))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

>>> tb/tb_lever_position_conditioner.sv
// ----------------------------------------------------------------------------
// tb_lever_position_conditioner: self-checking bench for the lever conditioner
// Feeds directed and randomized lever motion (ramps, holds, jumps, noise)
// through the sample channel. A local model of the window average,
// min/max scaling, dead zone, change step and snap predicts each reported
// slider value. Both channels idle at random, and the output side stalls for a
// long stretch once. Thresholds are changed between phases while the block is
// idle.
// ----------------------------------------------------------------------------
module tb_lever_position_conditioner
  import lpc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 64;
  localparam int LONG_HOLD_CYCLES = 1500;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [SAMPLE_W-1:0]  in_sample = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [VALUE_W-1:0]   out_slider_value;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VALUE_W-1:0]   cfg_data = '0;

  lever_position_conditioner dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_slider_value (out_slider_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5ns clk = ~clk;

  // Local copy of the conditioner state and thresholds.
  logic [SAMPLE_W-1:0] hist_ring [WINDOW];
  logic [PTR_W-1:0]    hist_ptr;
  logic [SUM_W-1:0]    hist_sum;
  logic [SAMPLE_W-1:0] low_seen;
  logic [SAMPLE_W-1:0] high_seen;
  logic [VALUE_W-1:0]  last_sent;
  bit                  first_pending;
  logic [VALUE_W-1:0]  dead_zone_q;
  logic [VALUE_W-1:0]  change_step_q;
  logic [VALUE_W-1:0]  snap_level_q;

  logic [SAMPLE_W-1:0] sample_queue [$];
  logic [VALUE_W-1:0]  slider_expect [$];

  int  error_count = 0;
  int  slider_checked = 0;
  int  cycle_count = 0;
  bit  in_idle = 1'b0;
  bit  out_idle = 1'b0;

  task automatic report_mismatch(string what);
    error_count++;
    $display("ERROR @%0t: %s", $realtime, what);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SAMPLE_W-1:0] clip_sample(int v);
    if (v < 0) return '0;
    if (v > SAMPLE_MAX) return SAMPLE_W'(SAMPLE_MAX);
    return SAMPLE_W'(v);
  endfunction

  function automatic void clear_conditioner();
    foreach (hist_ring[i]) hist_ring[i] = '0;
    hist_ptr      = '0;
    hist_sum      = '0;
    low_seen      = SAMPLE_W'(SAMPLE_MAX);
    high_seen     = '0;
    last_sent     = '0;
    first_pending = 1'b1;
    dead_zone_q   = DEAD_ZONE_RST;
    change_step_q = CHANGE_STEP_RST;
    snap_level_q  = SNAP_LEVEL_RST;
  endfunction

  // Advances the local state by one sample and queues the value it reports.
  function automatic void predict_slider(logic [SAMPLE_W-1:0] smp);
    logic [SAMPLE_W-1:0] avg;
    logic [VALUE_W-1:0]  value;
    logic [VALUE_W-1:0]  delta;
    int unsigned         scaled;
    hist_sum = hist_sum - hist_ring[hist_ptr] + smp;
    hist_ring[hist_ptr] = smp;
    if (smp > high_seen) high_seen = smp;
    if (smp < low_seen) low_seen = smp;
    hist_ptr = (hist_ptr == PTR_W'(WINDOW - 1)) ? '0 : hist_ptr + 1'b1;
    avg = SAMPLE_W'(hist_sum / WINDOW);
    // The ring may still hold reset zeros, so the average can sit below the minimum.
    if (first_pending || high_seen <= low_seen || avg <= low_seen) begin
      value = '0;
    end else begin
      scaled = (int'(avg - low_seen) * FULL_SCALE) / int'(high_seen - low_seen);
      value = VALUE_W'(scaled);
    end
    first_pending = 1'b0;
    if (value <= dead_zone_q) value = '0;
    delta = (value > last_sent) ? value - last_sent : last_sent - value;
    if (delta > change_step_q) begin
      if (value > snap_level_q) value = VALUE_W'(FULL_SCALE);
      last_sent = value;
      slider_expect.push_back(value);
    end
  endfunction

  // Sample channel driver.
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
      clear_conditioner();
    end else begin
      if (in_valid && in_ready) predict_slider(in_sample);
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          in_valid  <= 1'b1;
          in_sample <= sample_queue.pop_front();
          in_gap = in_idle ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Slider channel monitor with random stalls and one long hold-off.
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_armed = 1'b1;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (slider_expect.size() == 0) begin
          report_mismatch($sformatf("unexpected slider value %0d", out_slider_value));
        end else begin
          logic [VALUE_W-1:0] want;
          want = slider_expect.pop_front();
          if (out_slider_value !== want)
            report_mismatch($sformatf("slider value %0d, expected %0d",
                                      out_slider_value, want));
        end
        slider_checked++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (hold_armed && slider_checked >= 40) begin
        // Let the output register back up so the block stops taking samples.
        hold_armed = 1'b0;
        hold_left = LONG_HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (out_idle && $urandom_range(0, 5) == 0) begin
        stall_left = pick_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VALUE_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DEAD_ZONE:   dead_zone_q = data;
      REG_CHANGE_STEP: change_step_q = data;
      REG_SNAP_LEVEL:  snap_level_q = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_thresholds(int dz, int cs, int sl);
    write_reg(REG_DEAD_ZONE, VALUE_W'(dz));
    write_reg(REG_CHANGE_STEP, VALUE_W'(cs));
    write_reg(REG_SNAP_LEVEL, VALUE_W'(sl));
    @(negedge clk);
  endtask

  // Waits until every sample is taken and every reported value has arrived,
  // then gives a last sample that reports nothing time to finish.
  task automatic drain();
    do @(negedge clk);
    while (sample_queue.size() != 0 || in_valid || slider_expect.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Queues lever motion: mostly smooth moves and holds, some noise and jumps.
  task automatic queue_motion(int count);
    int added;
    int kind;
    int len;
    int a;
    int b;
    added = 0;
    while (added < count) begin
      kind = $urandom_range(0, 9);
      len = $urandom_range(4, 24);
      a = $urandom_range(0, SAMPLE_MAX);
      b = $urandom_range(0, SAMPLE_MAX);
      for (int k = 0; k < len; k++) begin
        case (kind)
          0, 1, 2: sample_queue.push_back(clip_sample(a + ((b - a) * k) / (len - 1)));
          3, 4:    sample_queue.push_back(clip_sample(a + $urandom_range(0, 40) - 20));
          5, 6:    sample_queue.push_back(clip_sample((k < len / 2) ? a : b));
          7:       sample_queue.push_back(SAMPLE_W'($urandom));
          8:       sample_queue.push_back(($urandom_range(0, 1) != 0) ?
                                          SAMPLE_W'(SAMPLE_MAX) : '0);
          default: begin
            a = a + $urandom_range(0, 400) - 200;
            sample_queue.push_back(clip_sample(a));
          end
        endcase
      end
      added += len;
    end
  endtask

  task automatic run_phase(int items, bit idle_in, bit idle_out);
    in_idle = idle_in;
    out_idle = idle_out;
    queue_motion(items);
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // First sample, a flat range, then an average still below the minimum
    // while the ring holds reset zeros; then full swings down and up to snap.
    sample_queue.push_back(SAMPLE_W'(2000));
    sample_queue.push_back(SAMPLE_W'(2000));
    sample_queue.push_back(SAMPLE_W'(3000));
    repeat (6) sample_queue.push_back(SAMPLE_W'(SAMPLE_MAX));
    repeat (8) sample_queue.push_back('0);
    repeat (8) sample_queue.push_back(SAMPLE_W'(SAMPLE_MAX));
    drain();

    run_phase(300, 1'b1, 1'b1);

    set_thresholds(0, 0, 0);
    run_phase(150, 1'b1, 1'b1);

    set_thresholds(0, 0, FULL_SCALE);
    run_phase(200, 1'b0, 1'b0);

    // Nothing can pass here; the write to the unused index must change nothing.
    set_thresholds(FULL_SCALE, FULL_SCALE, FULL_SCALE);
    write_reg(REG_UNUSED, '0);
    @(negedge clk);
    run_phase(60, 1'b1, 1'b0);

    repeat (4) begin
      set_thresholds($urandom_range(0, 4000), $urandom_range(0, 3000),
                     $urandom_range(0, FULL_SCALE));
      run_phase(150, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end

    set_thresholds(DEAD_ZONE_RST, CHANGE_STEP_RST, SNAP_LEVEL_RST);
    run_phase(200, 1'b0, 1'b1);

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
